// ----- hdl/hce_pkg.sv -----
// ----------------------------------------------------------------------------
// hce_pkg: shared definitions of the Huffman code-table encoder
// Command codes, default parameter values and stream field widths.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int SYMBOL_COUNT_DEF  = 256;
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int WORD_BITS         = 32;

    // input word fields
    localparam int SYMBOL_W   = 8;
    localparam int CODE_LEN_W = 6;
    localparam int CODE_W_IN  = 32;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [1:0]
    {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

endpackage

// ----- hdl/huffman_code_table_encoder.sv -----
// ----------------------------------------------------------------------------
// huffman_code_table_encoder: Huffman symbol encoder with a loaded code table
// Turns byte symbols into a packed MSB-first bit stream of Huffman codes.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser carries the command (load, encode, flush),
// tdata the symbol, code length and code word. A load writes one table entry,
// an encode appends the entry's code bits to the bit buffer, a flush pads the
// leftover bits with zeros and sends them as one byte.
// Output stream (m_axis): one packed byte per word, earliest bit in bit 7;
// tlast marks the final byte caused by one input word.
// Path: the table entry is read into the RAM's read register when an item is
// accepted; the pack stage then writes the item's bytes into the output
// buffer, which presents them on m_axis.
// Throughput: one input word per cycle while the items yield at most one
// byte and m_axis_tready stays high; an encode that yields several bytes
// (up to four for a 32-bit code) holds the next item until the output buffer,
// drained one byte a cycle while m_axis_tready is high, sends its last byte.
// Reset: all table entries read as unloaded (encodes of them are dropped and
// emit nothing), the bit buffer is empty and no output is pending.
// Stall: while m_axis_tready is low the buffered bytes hold; one more item
// waits in the pack stage, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module huffman_code_table_encoder
    import hce_pkg::*;
#(
    parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // symbol [7:0], code_length [13:8], code_word [45:14], zero [47:46]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd [1:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_byte [7:0]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int ADDR_W     = $clog2(SYMBOL_COUNT);
    localparam int CODE_W     = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int LEN_W      = $clog2(CODE_W + 1);
    localparam int ENTRY_W    = LEN_W + CODE_W;
    localparam int ACC_W      = CODE_W + 7;
    localparam int TOT_W      = $clog2(ACC_W + 1);
    localparam int NBYTES_MAX = ACC_W / 8;
    localparam int CNT_W      = $clog2(NBYTES_MAX + 1);

    // input word fields
    cmd_t                in_cmd;
    logic [SYMBOL_W-1:0] in_symbol;
    logic [CODE_LEN_W-1:0] in_len;
    logic [CODE_W_IN-1:0]  in_word;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_range;
    logic                in_accept;
    logic [LEN_W-1:0]    len_sat;
    logic                wr_en;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_entry;

    logic [SYMBOL_COUNT-1:0] entry_valid_reg;

    // pack stage
    logic s1_valid_reg;
    cmd_t s1_cmd_reg;
    logic s1_load;
    logic s1_go;

    logic [LEN_W-1:0]  s1_len;
    logic [CODE_W-1:0] s1_code;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  aligned;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  s1_nbytes;
    logic [NBYTES_MAX-1:0][7:0] s1_bytes;
    logic [6:0] pend_bits_next;
    logic [2:0] pend_cnt_next;

    logic [6:0] pend_bits_reg;
    logic [2:0] pend_cnt_reg;

    // output byte buffer
    logic [NBYTES_MAX-1:0][7:0] buf_byte_reg;
    logic [CNT_W-1:0]           buf_cnt_reg;
    logic                       out_accept;
    logic                       buf_free;

    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_symbol = s_axis_tdata[7:0];
    assign in_len    = s_axis_tdata[13:8];
    assign in_word   = s_axis_tdata[45:14];
    assign in_addr   = in_symbol[ADDR_W-1:0];
    assign in_range  = {1'b0, in_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // saturate overlong lengths to the stored code width
    assign len_sat = ({1'b0, in_len} > (CODE_LEN_W + 1)'(CODE_W)) ?
                     LEN_W'(CODE_W) : LEN_W'(in_len);

    assign wr_en = in_accept && (in_cmd == CMD_LOAD) && in_range;
    assign rd_en = in_accept && (in_cmd == CMD_ENCODE);

    hce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_addr),
        .wr_data ({len_sat, in_word[CODE_W-1:0]}),
        .rd_en   (rd_en),
        .rd_addr (in_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[in_addr] <= 1'b1;
        end
    end

    // only encodes of loaded entries and flushes reach the pack stage
    assign s1_load = in_accept &&
                     (((in_cmd == CMD_ENCODE) && in_range && entry_valid_reg[in_addr]) ||
                      (in_cmd == CMD_FLUSH));

    assign s_axis_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cmd_reg <= in_cmd;
        end
    end

    assign s1_len  = rd_entry[CODE_W +: LEN_W];
    assign s1_code = rd_entry[CODE_W-1:0];

    // append the code below the pending bits, then left-align the whole run
    assign acc = (ACC_W'(pend_bits_reg) << s1_len) |
                 ACC_W'(s1_code & ~({CODE_W{1'b1}} << s1_len));
    assign total   = TOT_W'(pend_cnt_reg) + TOT_W'(s1_len);
    assign aligned = acc << (TOT_W'(ACC_W) - total);

    always_comb
    begin
        s1_nbytes      = '0;
        s1_bytes       = '0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        unique case (s1_cmd_reg)
            CMD_ENCODE:
            begin
                s1_nbytes = CNT_W'(total >> 3);
                for (int i = 0; i < NBYTES_MAX; i++)
                begin
                    s1_bytes[i] = aligned[ACC_W-1-8*i -: 8];
                end
                pend_cnt_next  = total[2:0];
                pend_bits_next = acc[6:0] & ~(7'h7f << total[2:0]);
            end
            CMD_FLUSH:
            begin
                s1_nbytes      = (pend_cnt_reg != 3'd0) ? CNT_W'(1) : '0;
                s1_bytes[0]    = 8'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg}));
                pend_cnt_next  = '0;
                pend_bits_next = '0;
            end
            default:
            begin
                s1_nbytes = '0;
            end
        endcase
    end

    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign buf_free   = (buf_cnt_reg == '0) || ((buf_cnt_reg == CNT_W'(1)) && out_accept);
    // items that yield nothing pass the stage even while the buffer drains
    assign s1_go      = s1_valid_reg && ((s1_nbytes == '0) || buf_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else if (s1_go)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= '0;
        end
        else if (s1_go && (s1_nbytes != '0))
        begin
            buf_cnt_reg <= s1_nbytes;
        end
        else if (out_accept)
        begin
            buf_cnt_reg <= buf_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_nbytes != '0))
        begin
            buf_byte_reg <= s1_bytes;
        end
        else if (out_accept)
        begin
            // advance to the next byte
            for (int i = 0; i < NBYTES_MAX - 1; i++)
            begin
                buf_byte_reg[i] <= buf_byte_reg[i+1];
            end
        end
    end

    assign m_axis_tvalid = (buf_cnt_reg != '0);
    assign m_axis_tdata  = buf_byte_reg[0];
    assign m_axis_tlast  = (buf_cnt_reg == CNT_W'(1));

endmodule

// ----- hdl/hce_ram.sv -----
// ----------------------------------------------------------------------------
// hce_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/hce_checker.sv -----
// ----------------------------------------------------------------------------
// hce_checker: port-level checks of the Huffman code-table encoder
// Watches the output stream and the input ready over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hce_checker
    import hce_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output word changed while stalled");

    // the bytes of one item leave without a gap
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside the bytes of one item");

    // the input is held off only while output words wait
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output pending");

    // nothing is offered while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind huffman_code_table_encoder hce_checker u_hce_checker (.*);
